FILE: rtl/cid_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cid_pkg
// Shared types and constants for the connection ID allocator.
// ---------------------------------------------------------------------------
package cid_pkg;

   localparam int ID_SPACE_DEF = 256;
   localparam int ID_W         = 8;
   localparam int STATUS_W     = 2;
   localparam int GROUP_SIZE   = 16;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_POP,
      CMD_INSERT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         sample;
   } chain_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/connection_id_allocator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// connection_id_allocator
// Hands out IDs from 1 upward, reusing the largest released ID first.
// Acquire: result registered in the cycle after the request is taken; one per cycle
// unless a release is in progress or rsp_stall holds the response. Release: ID captured,
// group matches sampled (S_GROUP), update in S_APPLY, which waits on rsp_stall.
// Reset: free list empty and high-water mark at 1, usable the cycle after.
// ---------------------------------------------------------------------------
module connection_id_allocator #(
   parameter int ID_SPACE = cid_pkg::ID_SPACE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_opcode,
   input  wire logic [cid_pkg::ID_W-1:0]        req_release_id,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [cid_pkg::ID_W-1:0]        rsp_granted_id,
   output logic      [cid_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int KEY_W = $clog2(ID_SPACE);
   localparam int MW    = $clog2(ID_SPACE + 1);
   localparam int CW    = (MW > cid_pkg::ID_W) ? MW : cid_pkg::ID_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GROUP,
      S_APPLY
   } state_type;

   state_type                       state_ff;
   logic [MW-1:0]                   mark_ff;
   logic [cid_pkg::ID_W-1:0]        id_ff;
   logic                            rsp_valid_ff;
   logic [cid_pkg::ID_W-1:0]        rsp_granted_ff;
   logic [cid_pkg::STATUS_W-1:0]    rsp_status_ff;

   cid_pkg::chain_ctrl_type         ctrl;
   logic [KEY_W-1:0]                key;
   logic [KEY_W-1:0]                head_val;
   logic                            head_vld;
   logic                            dup;

   logic                            req_fire;
   logic                            rsp_fire;
   logic                            rsp_load;
   logic                            out_free;
   logic [CW-1:0]                   id_ext;
   logic [CW-1:0]                   mark_ext;
   logic                            id_bad;
   logic                            id_top;
   logic                            mark_room;

   assign req_stall      = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire       = req_valid && !req_stall;
   assign rsp_fire       = rsp_valid_ff && !rsp_stall;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_granted_ff;
   assign rsp_status     = rsp_status_ff;

   // a new result is loaded on an acquire transfer or when a release completes
   assign rsp_load = ((state_ff == S_IDLE) && req_fire &&
                      (req_opcode == cid_pkg::OP_ACQUIRE)) ||
                     ((state_ff == S_APPLY) && out_free);

   assign id_ext    = CW'(id_ff);
   assign mark_ext  = CW'(mark_ff);
   assign id_bad    = (id_ext == '0) || (id_ext >= mark_ext);
   assign id_top    = (CW'(id_ext + CW'(1)) == mark_ext);
   assign mark_room = (mark_ff < MW'(ID_SPACE));
   assign key       = KEY_W'(id_ff);

   // free-list command
   always_comb begin
      ctrl.cmd    = cid_pkg::CMD_HOLD;
      ctrl.sample = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_opcode == cid_pkg::OP_ACQUIRE) && head_vld) begin
               ctrl.cmd = cid_pkg::CMD_POP;
            end
         end
         S_GROUP: begin
            ctrl.sample = 1'b1;
         end
         S_APPLY: begin
            if (out_free && !id_bad && !dup && !id_top) begin
               ctrl.cmd = cid_pkg::CMD_INSERT;
            end
         end
         default: begin
            ctrl.cmd = cid_pkg::CMD_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mark_ff      <= MW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  id_ff <= req_release_id;
                  if (req_opcode == cid_pkg::OP_ACQUIRE) begin
                     priority if (head_vld) begin
                        rsp_granted_ff <= cid_pkg::ID_W'(head_val);
                        rsp_status_ff  <= cid_pkg::ST_OK;
                     end else if (mark_room) begin
                        rsp_granted_ff <= cid_pkg::ID_W'(mark_ff);
                        rsp_status_ff  <= cid_pkg::ST_OK;
                        mark_ff        <= MW'(mark_ff + MW'(1));
                     end else begin
                        rsp_granted_ff <= '0;
                        rsp_status_ff  <= cid_pkg::ST_EXHAUSTED;
                     end
                  end else begin
                     state_ff <= S_GROUP;
                  end
               end
            end
            S_GROUP: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (out_free) begin
                  rsp_granted_ff <= '0;
                  rsp_status_ff  <= id_bad ? cid_pkg::ST_BAD_RELEASE : cid_pkg::ST_OK;
                  if (!id_bad && !dup && id_top) begin
                     mark_ff <= MW'(id_ff);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   cid_chain #(
      .ID_SPACE (ID_SPACE)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .key      (key),
      .head_val (head_val),
      .head_vld (head_vld),
      .dup      (dup)
   );

endmodule

`default_nettype wire

FILE: rtl/cid_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cid_cell
// One slot of the sorted free list: holds one freed ID, shifts down when a
// larger ID is inserted above it and shifts up on pop.
// ---------------------------------------------------------------------------
module cid_cell #(
   parameter int KEY_W = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cid_pkg::cell_cmd_type cmd,
   input  wire logic [KEY_W-1:0]   key,
   input  wire logic [KEY_W-1:0]   up_val,
   input  wire logic               up_vld,
   input  wire logic               up_gt,
   input  wire logic [KEY_W-1:0]   dn_val,
   input  wire logic               dn_vld,
   output logic      [KEY_W-1:0]   val,
   output logic                    vld,
   output logic                    gt,
   output logic                    eq
);

   logic [KEY_W-1:0] val_ff, val_in;
   logic             vld_ff, vld_in;

   assign val = val_ff;
   assign vld = vld_ff;
   assign gt  = vld_ff && (val_ff > key);
   assign eq  = vld_ff && (val_ff == key);

   always_comb begin
      val_in = val_ff;
      vld_in = vld_ff;
      unique case (cmd)
         cid_pkg::CMD_POP: begin
            val_in = dn_val;
            vld_in = dn_vld;
         end
         cid_pkg::CMD_INSERT: begin
            if (gt) begin
               val_in = val_ff;
               vld_in = vld_ff;
            end else if (up_gt) begin
               val_in = key;
               vld_in = 1'b1;
            end else begin
               val_in = up_val;
               vld_in = up_vld;
            end
         end
         default: begin
            val_in = val_ff;
            vld_in = vld_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

`default_nettype wire

FILE: rtl/cid_chain.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cid_chain
// Row of cells holding freed IDs in descending order, largest at the head,
// with a registered two-level match tree for duplicate release detection.
// ---------------------------------------------------------------------------
module cid_chain #(
   parameter int ID_SPACE = cid_pkg::ID_SPACE_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cid_pkg::chain_ctrl_type      ctrl,
   input  wire logic [$clog2(ID_SPACE)-1:0]  key,
   output logic      [$clog2(ID_SPACE)-1:0]  head_val,
   output logic                              head_vld,
   output logic                              dup
);

   localparam int KEY_W = $clog2(ID_SPACE);
   localparam int NCELL = ID_SPACE - 1;
   localparam int GS    = cid_pkg::GROUP_SIZE;
   localparam int NGRP  = (NCELL + GS - 1) / GS;
   localparam int PADW  = NGRP * GS;

   logic [KEY_W-1:0] val [NCELL];
   logic [NCELL-1:0] vld;
   logic [NCELL-1:0] gt;
   logic [NCELL-1:0] eq;
   logic [PADW-1:0]  eq_pad;
   logic [NGRP-1:0]  grp_ff, grp_in;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      logic [KEY_W-1:0] up_val, dn_val;
      logic             up_vld, up_gt, dn_vld;

      if (i == 0) begin : g_head
         assign up_val = '0;
         assign up_vld = 1'b0;
         assign up_gt  = 1'b1;
      end else begin : g_mid_up
         assign up_val = val[i-1];
         assign up_vld = vld[i-1];
         assign up_gt  = gt[i-1];
      end

      if (i == NCELL - 1) begin : g_tail
         assign dn_val = '0;
         assign dn_vld = 1'b0;
      end else begin : g_mid_dn
         assign dn_val = val[i+1];
         assign dn_vld = vld[i+1];
      end

      cid_cell #(
         .KEY_W (KEY_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd    (ctrl.cmd),
         .key    (key),
         .up_val (up_val),
         .up_vld (up_vld),
         .up_gt  (up_gt),
         .dn_val (dn_val),
         .dn_vld (dn_vld),
         .val    (val[i]),
         .vld    (vld[i]),
         .gt     (gt[i]),
         .eq     (eq[i])
      );
   end

   assign eq_pad = PADW'(eq);

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = |eq_pad[g*GS +: GS];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sample) begin
         grp_ff <= grp_in;
      end
   end

   assign dup      = |grp_ff;
   assign head_val = val[0];
   assign head_vld = vld[0];

endmodule

`default_nettype wire
